// ----- rtl/ras_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_pkg
// Shared types and constants of the record average selection sort.
// ----------------------------------------------------------------------------
package ras_pkg;

  localparam int unsigned ScoreW   = 10;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef logic [ScoreW-1:0] score_t;

  typedef struct packed {
    score_t average;
    score_t second;
    score_t first;
  } record_t;

endpackage

// ----- rtl/record_average_selection_sort_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_average_selection_sort_top
// Loads a run of records, sorts them by descending average with a selection
// sort over a record memory and streams the sorted run out.
//
// channel  dir  tdata (lsb first)                        tlast
// s_axis   in   score_first, score_second                -
// m_axis   out  out_first, out_second, out_average       is_last
//
// loading writes each accepted record into the memory; the last record starts the sort
// sort position i scans records i to RECORDS - 1 on the single memory read port
// readout reads each record (registered memory read) and loads it once the output is free
// s_axis_tready_o is low from the
// last record of a run until the last sorted record is handed to the output
// reset clears control state only; the record memory needs no clearing
// ----------------------------------------------------------------------------
module record_average_selection_sort_top #(
  parameter int unsigned RECORDS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ras_pkg::InDataW-1:0]    s_axis_tdata_i,  // score_first, score_second
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ras_pkg::OutDataW-1:0]   m_axis_tdata_o,  // out_first, out_second, out_average
  output logic                           m_axis_tlast_o   // is_last
);

  localparam int unsigned IdxW = $clog2(RECORDS);
  localparam int unsigned SW   = ras_pkg::ScoreW;

  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  ras_pkg::record_t wr_data;
  logic [IdxW-1:0]  rd_addr;
  ras_pkg::record_t rd_data;
  logic             out_free;
  logic             out_load;
  ras_pkg::record_t out_rec;
  logic             out_last;

  logic             out_valid_q;
  ras_pkg::record_t out_rec_q;
  logic             out_last_q;

  ras_store #(
    .Depth (RECORDS),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ras_ctrl #(
    .Records (RECORDS),
    .IdxW    (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_first_i  (s_axis_tdata_i[SW-1:0]),
    .in_second_i (s_axis_tdata_i[2*SW-1:SW]),
    .in_ready_o  (s_axis_tready_o),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_rec_o   (out_rec),
    .out_last_o  (out_last),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q  <= out_rec;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_rec_q.average, out_rec_q.second, out_rec_q.first};

endmodule

// ----- rtl/ras_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_store
// Record memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ras_store #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  ras_pkg::record_t wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output ras_pkg::record_t rd_data_o
);

  ras_pkg::record_t mem_q [Depth];
  ras_pkg::record_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/ras_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_ctrl
// Sequencer: loads records, runs the selection sort with one shared average
// comparator over the memory, swaps records and reads out the sorted run.
// ----------------------------------------------------------------------------
module ras_ctrl #(
  parameter int unsigned Records = 8,
  parameter int unsigned IdxW    = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ras_pkg::score_t  in_first_i,
  input  ras_pkg::score_t  in_second_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  output logic             out_load_o,
  output ras_pkg::record_t out_rec_o,
  output logic             out_last_o,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output ras_pkg::record_t wr_data_o,
  output logic [IdxW-1:0]  rd_addr_o,
  input  ras_pkg::record_t rd_data_i
);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StSwap1  = 3'd2;
  localparam logic [2:0] StSwap2  = 3'd3;
  localparam logic [2:0] StEmitRd = 3'd4;
  localparam logic [2:0] StEmitLd = 3'd5;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Records - 1);
  localparam logic [IdxW-1:0] LastOuter = IdxW'(Records - 2);

  logic [2:0]       state_q, state_d;
  logic [IdxW-1:0]  load_cnt_q, load_cnt_d;
  logic [IdxW-1:0]  outer_q, outer_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [IdxW-1:0]  emit_idx_q, emit_idx_d;
  logic [IdxW-1:0]  data_idx_q;
  logic             data_ok_q;
  ras_pkg::record_t best_rec_q, best_rec_d;
  ras_pkg::record_t cur_rec_q, cur_rec_d;
  ras_pkg::record_t in_rec;
  logic [ras_pkg::ScoreW:0] score_sum;

  assign score_sum       = {1'b0, in_first_i} + {1'b0, in_second_i};
  assign in_rec.first    = in_first_i;
  assign in_rec.second   = in_second_i;
  assign in_rec.average  = score_sum[ras_pkg::ScoreW:1];

  assign in_ready_o = (state_q == StLoad);
  assign out_rec_o  = rd_data_i;
  assign out_last_o = (emit_idx_q == LastIdx);

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    outer_d    = outer_q;
    rd_idx_d   = rd_idx_q;
    best_idx_d = best_idx_q;
    emit_idx_d = emit_idx_q;
    best_rec_d = best_rec_q;
    cur_rec_d  = cur_rec_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = load_cnt_q;
    wr_data_o  = in_rec;
    rd_addr_o  = rd_idx_q;
    out_load_o = 1'b0;
    case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          wr_en_o = 1'b1;
          if (load_cnt_q == LastIdx) begin
            load_cnt_d = '0;
            outer_d    = '0;
            rd_idx_d   = '0;
            state_d    = StScan;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      StScan: begin
        if (rd_idx_q != LastIdx) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (data_ok_q) begin
          if (data_idx_q == outer_q) begin
            cur_rec_d  = rd_data_i;
            best_rec_d = rd_data_i;
            best_idx_d = data_idx_q;
          end else if (rd_data_i.average > best_rec_q.average) begin
            best_rec_d = rd_data_i;
            best_idx_d = data_idx_q;
          end
          if (data_idx_q == LastIdx) begin
            state_d = StSwap1;
          end
        end
      end
      StSwap1: begin
        wr_en_o   = 1'b1;
        wr_addr_o = outer_q;
        wr_data_o = best_rec_q;
        state_d   = StSwap2;
      end
      StSwap2: begin
        wr_en_o   = 1'b1;
        wr_addr_o = best_idx_q;
        wr_data_o = cur_rec_q;
        if (outer_q == LastOuter) begin
          emit_idx_d = '0;
          state_d    = StEmitRd;
        end else begin
          outer_d  = outer_q + 1'b1;
          rd_idx_d = outer_q + 1'b1;
          state_d  = StScan;
        end
      end
      StEmitRd: begin
        rd_addr_o = emit_idx_q;
        state_d   = StEmitLd;
      end
      StEmitLd: begin
        rd_addr_o = emit_idx_q;
        if (out_free_i) begin
          out_load_o = 1'b1;
          if (emit_idx_q == LastIdx) begin
            state_d = StLoad;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      load_cnt_q <= '0;
      outer_q    <= '0;
      rd_idx_q   <= '0;
      best_idx_q <= '0;
      emit_idx_q <= '0;
      data_idx_q <= '0;
      data_ok_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      outer_q    <= outer_d;
      rd_idx_q   <= rd_idx_d;
      best_idx_q <= best_idx_d;
      emit_idx_q <= emit_idx_d;
      data_idx_q <= rd_idx_q;
      data_ok_q  <= (state_q == StScan);
    end
  end

  always_ff @(posedge clk_i) begin
    best_rec_q <= best_rec_d;
    cur_rec_q  <= cur_rec_d;
  end

  a_best_not_before_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSwap1) |-> (best_idx_q >= outer_q))
    else $error("best index below outer position");

  a_best_not_smaller: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSwap2) |-> (best_rec_q.average >= cur_rec_q.average))
    else $error("selected record has smaller average");

  a_last_returns_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o && out_last_o) |=> (state_q == StLoad))
    else $error("no return to loading after last record");

  a_count_idle_outside_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (load_cnt_q == '0))
    else $error("load count nonzero outside loading");

endmodule
